// File: src/bod_pkg.sv
// Shared types, constants and decode functions for the bytecode operand decoder.
// Used by bod_front, bod_queue, bod_back and bytecode_operand_decoder.
`default_nettype none

package bod_pkg;

  // Addressing modes (nibble values).
  localparam logic [3:0] MODE_NONE     = 4'd0;
  localparam logic [3:0] MODE_REG_S    = 4'd1;
  localparam logic [3:0] MODE_REG_AB   = 4'd2;
  localparam logic [3:0] MODE_REG_I    = 4'd3;
  localparam logic [3:0] MODE_REG_L    = 4'd4;
  localparam logic [3:0] MODE_IMM8     = 4'd5;
  localparam logic [3:0] MODE_IMM16    = 4'd6;
  localparam logic [3:0] MODE_IMM32    = 4'd7;
  localparam logic [3:0] MODE_STRING   = 4'd8;
  localparam logic [3:0] MODE_IDX_I    = 4'd9;
  localparam logic [3:0] MODE_IDX_R    = 4'd10;
  localparam logic [3:0] MODE_IDX_R_OI = 4'd11;
  localparam logic [3:0] MODE_IDX_I_LI = 4'd12;
  localparam logic [3:0] MODE_IDX_I_LR = 4'd13;
  localparam logic [3:0] MODE_IDX_R_LI = 4'd14;
  localparam logic [3:0] MODE_IDX_R_LR = 4'd15;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OPERR = 2'd2;

  // Register types.
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_I = 3'd1;
  localparam logic [2:0] REG_L = 3'd2;
  localparam logic [2:0] REG_S = 3'd3;
  localparam logic [2:0] REG_F = 3'd4;
  localparam logic [2:0] REG_A = 3'd5;

  // Register code range bounds.
  localparam logic [7:0] CODE_B_HI   = 8'h0F;
  localparam logic [7:0] CODE_I_HI   = 8'h17;
  localparam logic [7:0] CODE_L_HI   = 8'h1B;
  localparam logic [7:0] CODE_S_HI   = 8'h23;
  localparam logic [7:0] CODE_F_HI   = 8'h2B;
  localparam logic [7:0] CODE_S2_HI  = 8'h33;
  localparam logic [7:0] CODE_A_LO   = 8'h80;
  localparam logic [7:0] CODE_A_HI   = 8'h8F;
  localparam logic [7:0] CODE_I2_LO  = 8'h90;
  localparam logic [7:0] CODE_I2_HI  = 8'h97;
  localparam logic [7:0] CODE_L2_LO  = 8'h98;
  localparam logic [7:0] CODE_L2_HI  = 8'h9B;
  localparam logic [7:0] CODE_S_BASE = 8'h1C;
  localparam logic [7:0] CODE_F_BASE = 8'h24;  // also S8..S15 base (0x2C - 8)
  localparam logic [7:0] CODE_L2_BASE = 8'h94; // 0x98 - 4

  // Byte roles inside an operand.
  localparam logic [3:0] ROLE_NONE = 4'd0;
  localparam logic [3:0] ROLE_BASE = 4'd1;
  localparam logic [3:0] ROLE_RA   = 4'd2;
  localparam logic [3:0] ROLE_RB   = 4'd3;
  localparam logic [3:0] ROLE_VA0  = 4'd4;
  localparam logic [3:0] ROLE_VA1  = 4'd5;
  localparam logic [3:0] ROLE_VA2  = 4'd6;
  localparam logic [3:0] ROLE_VA3  = 4'd7;
  localparam logic [3:0] ROLE_VB0  = 4'd8;
  localparam logic [3:0] ROLE_VB1  = 4'd9;

  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  base_s;
    logic [2:0]  ra_type;
    logic [3:0]  ra_idx;
    logic [2:0]  rb_type;
    logic [3:0]  rb_idx;
    logic [15:0] value_b;
  } fields_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  rtype;
    logic [3:0]  idx;
  } reg_dec_t;

  typedef struct packed {
    logic [7:0]         opcode;
    logic               slot;
    logic [3:0]         addr_mode;
    logic [1:0]         status;
    logic [2:0]         reg_a_type;
    logic [3:0]         reg_a_index;
    logic [2:0]         reg_b_type;
    logic [3:0]         reg_b_index;
    logic [3:0]         base_s;
    logic signed [31:0] value_a;
    logic signed [15:0] value_b;
    logic [23:0]        end_offset;
  } result_t;

  // One queue entry: the results of one byte, one or two.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

  function automatic reg_dec_t decode_reg(input logic [7:0] c);
    reg_dec_t d;
    d = '0;
    d.ok = 1'b1;
    if (c <= CODE_B_HI) begin
      d.rtype = REG_B; d.idx = c[3:0];
    end else if (c <= CODE_I_HI) begin
      d.rtype = REG_I; d.idx = {1'b0, c[2:0]};
    end else if (c <= CODE_L_HI) begin
      d.rtype = REG_L; d.idx = {2'b00, c[1:0]};
    end else if (c <= CODE_S_HI) begin
      d.rtype = REG_S; d.idx = 4'(c - CODE_S_BASE);
    end else if (c <= CODE_F_HI) begin
      d.rtype = REG_F; d.idx = 4'(c - CODE_F_BASE);
    end else if (c <= CODE_S2_HI) begin
      d.rtype = REG_S; d.idx = 4'(c - CODE_F_BASE);
    end else if (c >= CODE_A_LO && c <= CODE_A_HI) begin
      d.rtype = REG_A; d.idx = c[3:0];
    end else if (c >= CODE_I2_LO && c <= CODE_I2_HI) begin
      d.rtype = REG_I; d.idx = {1'b1, c[2:0]};
    end else if (c >= CODE_L2_LO && c <= CODE_L2_HI) begin
      d.rtype = REG_L; d.idx = 4'(c - CODE_L2_BASE);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  // Operand byte count for each mode.
  function automatic logic [2:0] op_len(input logic [3:0] m);
    logic [2:0] n;
    case (m)
      MODE_NONE:                              n = 3'd0;
      MODE_REG_S, MODE_REG_AB, MODE_REG_I,
      MODE_REG_L, MODE_IMM8:                  n = 3'd1;
      MODE_IMM16, MODE_STRING, MODE_IDX_R:    n = 3'd2;
      MODE_IDX_I, MODE_IDX_R_LR:              n = 3'd3;
      MODE_IMM32, MODE_IDX_R_OI,
      MODE_IDX_I_LR, MODE_IDX_R_LI:           n = 3'd4;
      MODE_IDX_I_LI:                          n = 3'd5;
      default:                                n = 3'd0;
    endcase
    return n;
  endfunction

  // Role of operand byte k in mode m.
  function automatic logic [3:0] op_role(input logic [3:0] m, input logic [2:0] k);
    logic [19:0] r;  // byte 0 in [19:16] ... byte 4 in [3:0]
    logic [3:0]  sel;
    r = '0;
    case (m)
      MODE_REG_S, MODE_REG_AB, MODE_REG_I, MODE_REG_L:
        r = {ROLE_RA, 16'h0};
      MODE_IMM8:     r = {ROLE_VA0, 16'h0};
      MODE_IMM16, MODE_STRING:
        r = {ROLE_VA0, ROLE_VA1, 12'h0};
      MODE_IMM32:    r = {ROLE_VA0, ROLE_VA1, ROLE_VA2, ROLE_VA3, ROLE_NONE};
      MODE_IDX_I:    r = {ROLE_BASE, ROLE_VA0, ROLE_VA1, 8'h0};
      MODE_IDX_R:    r = {ROLE_BASE, ROLE_RA, 12'h0};
      MODE_IDX_R_OI, MODE_IDX_R_LI:
        r = {ROLE_BASE, ROLE_RA, ROLE_VB0, ROLE_VB1, ROLE_NONE};
      MODE_IDX_I_LI: r = {ROLE_BASE, ROLE_VA0, ROLE_VA1, ROLE_VB0, ROLE_VB1};
      MODE_IDX_I_LR: r = {ROLE_BASE, ROLE_VA0, ROLE_VA1, ROLE_RB, ROLE_NONE};
      MODE_IDX_R_LR: r = {ROLE_BASE, ROLE_RA, ROLE_RB, 8'h0};
      default:       r = '0;
    endcase
    case (k)
      3'd0:    sel = r[19:16];
      3'd1:    sel = r[15:12];
      3'd2:    sel = r[11:8];
      3'd3:    sel = r[7:4];
      3'd4:    sel = r[3:0];
      default: sel = ROLE_NONE;
    endcase
    return sel;
  endfunction

  function automatic logic [31:0] value_a_of(input logic [3:0] m, input logic [31:0] w);
    logic [31:0] v;
    case (m)
      MODE_IMM8:  v = {{24{w[7]}}, w[7:0]};
      MODE_IMM16, MODE_IDX_I, MODE_IDX_I_LI, MODE_IDX_I_LR:
                  v = {{16{w[15]}}, w[15:0]};
      MODE_IMM32: v = w;
      MODE_STRING: v = {16'h0, w[15:0]};
      default:    v = '0;
    endcase
    return v;
  endfunction

  function automatic result_t make_result(
    input logic [7:0]  opc,
    input logic        sl,
    input logic [3:0]  md,
    input logic [1:0]  st,
    input fields_t     pf,
    input logic [31:0] gw,
    input logic [23:0] endo
  );
    result_t r;
    r = '0;
    r.opcode     = opc;
    r.status     = st;
    r.end_offset = endo;
    if (st != ST_TRUNC) begin
      r.slot      = sl;
      r.addr_mode = md;
    end
    if (st == ST_OK) begin
      r.reg_a_type  = pf.ra_type;
      r.reg_a_index = pf.ra_idx;
      r.reg_b_type  = pf.rb_type;
      r.reg_b_index = pf.rb_idx;
      r.base_s      = pf.base_s;
      r.value_a     = value_a_of(md, gw);
      r.value_b     = pf.value_b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/bytecode_operand_decoder.sv
// Top level of the bytecode operand decoder: parser front end, result queue,
// output stage. Depends on bod_pkg, bod_front, bod_queue and bod_back.
`default_nettype none

// The decoder takes a bytecode buffer one byte per transfer on the byte
// channel and returns one result per finished operand on the result
// channel. Each instruction is an opcode byte, a mode byte (high nibble
// operand 0, low nibble operand 1) and the operand bytes; strings are
// skipped by their length prefix. Bad registers, a non-S base or a buffer
// that ends early give an error result, and bytes are then dropped until
// the next byte with start_req. Throughput is one byte per cycle while
// byte_stall is low: the parser pushes the one or two results of a byte,
// if it finishes any, as one entry into a four-entry queue. The output
// stage drains one result per cycle while result_stall is low, so a byte
// that finishes two operands takes two output transfers; byte_stall rises
// only when the queue is full. A result passes through the queue and then
// the output register. OFFSET_BITS sets the width of the position counter,
// which wraps; end_offset shows its low 24 bits.

module bytecode_operand_decoder #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte channel
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire logic [7:0]         code_byte,
  input  wire logic               start_req,
  input  wire logic               last,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [7:0]              opcode,
  output logic                    slot,
  output logic [3:0]              addr_mode,
  output logic [1:0]              status,
  output logic [2:0]              reg_a_type,
  output logic [3:0]              reg_a_index,
  output logic [2:0]              reg_b_type,
  output logic [3:0]              reg_b_index,
  output logic [3:0]              base_s,
  output logic signed [31:0]      value_a,
  output logic signed [15:0]      value_b,
  output logic [23:0]             end_offset
);

  logic             q_full;
  logic             q_not_empty;
  logic             push;
  logic             pop;
  bod_pkg::pair_t   push_data;
  bod_pkg::pair_t   head;
  bod_pkg::result_t result;

  // stall depends on queue occupancy only
  assign byte_stall = q_full;

  bod_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .code_byte  (code_byte),
    .start_req  (start_req),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  bod_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  bod_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (q_not_empty),
    .head         (head),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  // fields of the output register
  assign opcode      = result.opcode;
  assign slot        = result.slot;
  assign addr_mode   = result.addr_mode;
  assign status      = result.status;
  assign reg_a_type  = result.reg_a_type;
  assign reg_a_index = result.reg_a_index;
  assign reg_b_type  = result.reg_b_type;
  assign reg_b_index = result.reg_b_index;
  assign base_s      = result.base_s;
  assign value_a     = result.value_a;
  assign value_b     = result.value_b;
  assign end_offset  = result.end_offset;

endmodule

`default_nettype wire

// File: src/bod_front.sv
// Front end: byte parser. Takes one byte per transfer and builds the 0..2
// results it finishes as one queue entry. Depends on bod_pkg.
`default_nettype none

module bod_front #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  input  wire logic [7:0]    code_byte,
  input  wire logic          start_req,
  input  wire logic          last,
  input  wire logic          q_full,
  output logic               push,
  output bod_pkg::pair_t     push_data
);

  typedef enum logic [1:0] {PH_OPCODE, PH_MODE, PH_OPER, PH_SKIP} phase_t;

  phase_t                 phase, phase_next;
  logic [2:0]             oper_k, oper_k_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [7:0]             held_opcode, held_opcode_next;
  logic [3:0]             second_mode, second_mode_next;
  logic                   current_slot, current_slot_next;
  logic [3:0]             current_mode, current_mode_next;
  logic [31:0]            gather_word, gather_word_next;
  logic [15:0]            bytes_remaining, bytes_remaining_next;
  bod_pkg::fields_t       partial, partial_next;
  logic                   dropping, dropping_next;

  logic                   accept;
  logic [1:0]             n;
  bod_pkg::result_t       res [2];
  logic [23:0]            endo;
  logic                   skip_all;
  logic                   errored;
  logic                   do_close;
  logic                   ok;
  logic [3:0]             role;
  bod_pkg::reg_dec_t      dec;

  assign accept = byte_valid && !q_full;

  always_comb begin
    phase_next           = phase;
    oper_k_next          = oper_k;
    held_opcode_next     = held_opcode;
    second_mode_next     = second_mode;
    current_slot_next    = current_slot;
    current_mode_next    = current_mode;
    gather_word_next     = gather_word;
    bytes_remaining_next = bytes_remaining;
    partial_next         = partial;
    dropping_next        = dropping;
    byte_position_next   = byte_position + OFFSET_BITS'(1);

    // start of a new buffer: parser back to reset before the byte is used
    if (start_req) begin
      phase_next           = PH_OPCODE;
      oper_k_next          = '0;
      held_opcode_next     = '0;
      second_mode_next     = '0;
      current_slot_next    = 1'b0;
      current_mode_next    = '0;
      gather_word_next     = '0;
      bytes_remaining_next = '0;
      partial_next         = '0;
      dropping_next        = 1'b0;
      byte_position_next   = OFFSET_BITS'(1);
    end

    endo     = 24'(byte_position_next);
    skip_all = dropping_next;
    n        = '0;
    res[0]   = '0;
    res[1]   = '0;
    errored  = 1'b0;
    do_close = 1'b0;
    ok       = 1'b1;
    role     = bod_pkg::ROLE_NONE;
    dec      = bod_pkg::decode_reg(code_byte);

    if (!skip_all) begin
      case (phase_next)
        PH_OPCODE: begin
          held_opcode_next  = code_byte;
          current_slot_next = 1'b0;
          current_mode_next = '0;
          phase_next        = PH_MODE;
        end
        PH_MODE: begin
          current_mode_next    = code_byte[7:4];
          second_mode_next     = code_byte[3:0];
          current_slot_next    = 1'b0;
          partial_next         = '0;
          gather_word_next     = '0;
          bytes_remaining_next = '0;
          oper_k_next          = '0;
          if (bod_pkg::op_len(current_mode_next) != 3'd0) begin
            phase_next = PH_OPER;
          end else begin
            res[n[0]] = bod_pkg::make_result(held_opcode_next, 1'b0, current_mode_next,
                          bod_pkg::ST_OK, partial_next, gather_word_next, endo);
            n = n + 2'd1;
            current_slot_next = 1'b1;
            current_mode_next = second_mode_next;
            if (bod_pkg::op_len(current_mode_next) != 3'd0) begin
              phase_next = PH_OPER;
            end else begin
              res[n[0]] = bod_pkg::make_result(held_opcode_next, 1'b1, current_mode_next,
                            bod_pkg::ST_OK, partial_next, gather_word_next, endo);
              n = n + 2'd1;
              phase_next = PH_OPCODE;
            end
          end
        end
        PH_SKIP: begin
          if (bytes_remaining_next != 16'd0) begin
            bytes_remaining_next = bytes_remaining_next - 16'd1;
          end
          if (bytes_remaining_next == 16'd0) begin
            do_close = 1'b1;
          end
        end
        PH_OPER: begin
          role = bod_pkg::op_role(current_mode_next, oper_k_next);
          case (role)
            bod_pkg::ROLE_BASE: begin
              ok = dec.ok && (dec.rtype == bod_pkg::REG_S);
              partial_next.base_s = dec.idx;
            end
            bod_pkg::ROLE_RA: begin
              ok = dec.ok;
              partial_next.ra_type = dec.rtype;
              partial_next.ra_idx  = dec.idx;
            end
            bod_pkg::ROLE_RB: begin
              ok = dec.ok;
              partial_next.rb_type = dec.rtype;
              partial_next.rb_idx  = dec.idx;
            end
            bod_pkg::ROLE_VA0: gather_word_next[7:0]   = code_byte;
            bod_pkg::ROLE_VA1: gather_word_next[15:8]  = code_byte;
            bod_pkg::ROLE_VA2: gather_word_next[23:16] = code_byte;
            bod_pkg::ROLE_VA3: gather_word_next[31:24] = code_byte;
            bod_pkg::ROLE_VB0: partial_next.value_b[7:0]  = code_byte;
            bod_pkg::ROLE_VB1: partial_next.value_b[15:8] = code_byte;
            default: ;
          endcase
          if (!ok) begin
            res[n[0]] = bod_pkg::make_result(held_opcode_next, current_slot_next,
                          current_mode_next, bod_pkg::ST_OPERR, partial_next,
                          gather_word_next, endo);
            n = n + 2'd1;
            errored       = 1'b1;
            dropping_next = 1'b1;
            phase_next    = PH_OPCODE;
          end else if (({1'b0, oper_k_next} + 4'd1) >=
                       {1'b0, bod_pkg::op_len(current_mode_next)}) begin
            // string with nonzero length: skip its body
            if (current_mode_next == bod_pkg::MODE_STRING &&
                gather_word_next[15:0] != 16'd0) begin
              bytes_remaining_next = gather_word_next[15:0];
              phase_next           = PH_SKIP;
            end else begin
              do_close = 1'b1;
            end
          end else begin
            oper_k_next = oper_k_next + 3'd1;
          end
        end
        default: ;
      endcase

      if (do_close) begin
        res[n[0]] = bod_pkg::make_result(held_opcode_next, current_slot_next,
                      current_mode_next, bod_pkg::ST_OK, partial_next,
                      gather_word_next, endo);
        n = n + 2'd1;
        if (current_slot_next) begin
          phase_next = PH_OPCODE;
        end else begin
          current_slot_next    = 1'b1;
          current_mode_next    = second_mode_next;
          partial_next         = '0;
          gather_word_next     = '0;
          bytes_remaining_next = '0;
          oper_k_next          = '0;
          if (bod_pkg::op_len(current_mode_next) != 3'd0) begin
            phase_next = PH_OPER;
          end else begin
            res[n[0]] = bod_pkg::make_result(held_opcode_next, 1'b1, current_mode_next,
                          bod_pkg::ST_OK, partial_next, gather_word_next, endo);
            n = n + 2'd1;
            phase_next = PH_OPCODE;
          end
        end
      end

      // end of buffer with an instruction still open
      if (last) begin
        if (!errored && phase_next != PH_OPCODE) begin
          res[n[0]] = bod_pkg::make_result(held_opcode_next, current_slot_next,
                        current_mode_next,
                        (phase_next == PH_MODE) ? bod_pkg::ST_TRUNC : bod_pkg::ST_OPERR,
                        partial_next, gather_word_next, endo);
          n = n + 2'd1;
        end
        dropping_next = 1'b1;
        phase_next    = PH_OPCODE;
      end
    end
  end

  assign push             = accept && (n != 2'd0);
  assign push_data.two    = n[1];
  assign push_data.first  = res[0];
  assign push_data.second = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_OPCODE;
      oper_k          <= '0;
      byte_position   <= '0;
      held_opcode     <= '0;
      second_mode     <= '0;
      current_slot    <= 1'b0;
      current_mode    <= '0;
      gather_word     <= '0;
      bytes_remaining <= '0;
      partial         <= '0;
      dropping        <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      oper_k          <= oper_k_next;
      byte_position   <= byte_position_next;
      held_opcode     <= held_opcode_next;
      second_mode     <= second_mode_next;
      current_slot    <= current_slot_next;
      current_mode    <= current_mode_next;
      gather_word     <= gather_word_next;
      bytes_remaining <= bytes_remaining_next;
      partial         <= partial_next;
      dropping        <= dropping_next;
    end
  end

endmodule

`default_nettype wire

// File: src/bod_queue.sv
// Small FIFO of result pairs between the parser and the output stage.
// Depends on bod_pkg.
`default_nettype none

module bod_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bod_pkg::pair_t  push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output bod_pkg::pair_t       head
);

  localparam int PW = $clog2(bod_pkg::Q_DEPTH);

  bod_pkg::pair_t mem [bod_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign full      = (count == (PW+1)'(bod_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bod_back.sv
// Back end: output register. Sends the one or two results of each queue
// entry, one transfer per cycle while result_stall is low. Depends on bod_pkg.
`default_nettype none

module bod_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            not_empty,
  input  wire bod_pkg::pair_t  head,
  output logic                 pop,
  input  wire logic            result_stall,
  output logic                 result_valid,
  output bod_pkg::result_t     result
);

  logic sel;   // 1: first result of the head entry already sent
  logic load;

  assign load = not_empty && (!result_valid || !result_stall);
  assign pop  = load && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      sel          <= !(sel || !head.two);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= sel ? head.second : head.first;
    end
  end

endmodule

`default_nettype wire
